>>> design/bmhc_pkg.sv
// Shared types and constants for the button multi-tap and hold counter.
`default_nettype none

package bmhc_pkg;

    // Register map, indexed by paddr[3:2]
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_GAP      = 2'd1;
    localparam logic [1:0] REG_REPEAT   = 2'd2;
    localparam logic [1:0] REG_HOLD_LVL = 2'd3;

    // Register reset values
    localparam logic [15:0] RST_DEBOUNCE_MS = 16'd50;
    localparam logic [15:0] RST_GAP_MS      = 16'd500;
    localparam logic [15:0] RST_REPEAT_MS   = 16'd500;

    // Report kinds
    localparam logic KIND_TAP  = 1'b0;
    localparam logic KIND_HOLD = 1'b1;

    // Edge count saturation point
    localparam logic signed [7:0] EDGE_MAX = 8'sd127;

    // Command queue sizing
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Divider iteration count and counter width
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // One classified sample: an optional tap report and an optional hold report
    typedef struct packed {
        logic        tap_vld;
        logic [5:0]  tap_val;
        logic        hold_vld;
        logic [31:0] held_ms;
        logic [15:0] rep_ms;
    } t_cmd;

endpackage

`default_nettype wire

>>> design/bmhc_front.sv
// Front end: debounce, edge counting and classification of each sample.
`default_nettype none

module bmhc_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic              i_pin_level,
    input  wire logic [31:0]       i_now_ms,
    input  wire logic [15:0]       i_debounce_ms,
    input  wire logic [15:0]       i_gap_ms,
    input  wire logic [15:0]       i_repeat_ms,
    input  wire logic              i_hold_level,
    output logic                   o_push,
    output bmhc_pkg::t_cmd         o_cmd
);
    import bmhc_pkg::*;

    logic               r_stable;
    logic               r_prev;
    logic [31:0]        r_last_change;
    logic signed [7:0]  r_edge_cnt;
    logic [31:0]        r_last_report;

    logic               n_stable;
    logic [31:0]        n_last_change;
    logic signed [7:0]  n_edge_cnt;
    logic [31:0]        n_last_report;

    logic [31:0]        quiet;
    logic               settled;
    logic               past_gap;
    logic signed [7:0]  cnt_edge;
    logic               tap;
    logic               hold;
    logic [15:0]        rep;
    logic [31:0]        since_report;

    // Classify the sample against the debounce, gap and repeat timers
    always_comb begin
        n_last_change = (i_pin_level != r_prev) ? i_now_ms : r_last_change;
        quiet         = i_now_ms - n_last_change;
        settled       = quiet > {16'd0, i_debounce_ms};
        past_gap      = quiet > {16'd0, i_gap_ms};
        rep           = (i_repeat_ms == 16'd0) ? 16'd1 : i_repeat_ms;
        since_report  = i_now_ms - r_last_report;

        n_stable   = r_stable;
        cnt_edge   = r_edge_cnt;
        if (settled && (i_pin_level != r_stable)) begin
            n_stable = i_pin_level;
            if (r_edge_cnt < EDGE_MAX) begin
                cnt_edge = r_edge_cnt + 8'sd1;
            end
        end

        tap  = settled && (cnt_edge > 8'sd1) && past_gap;
        hold = settled && (since_report > {16'd0, rep}) &&
               (i_pin_level == i_hold_level) && past_gap;

        n_edge_cnt = cnt_edge;
        if (tap) begin
            n_edge_cnt = 8'sd0;
        end
        if (hold) begin
            n_edge_cnt = -8'sd1;
        end
        n_last_report = hold ? i_now_ms : r_last_report;

        o_cmd.tap_vld  = tap;
        o_cmd.tap_val  = cnt_edge[6:1];
        o_cmd.hold_vld = hold;
        o_cmd.held_ms  = quiet - {16'd0, i_gap_ms};
        o_cmd.rep_ms   = rep;
        o_push         = i_accept && (tap || hold);
    end

    // Advance the tracking state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable      <= 1'b0;
            r_prev        <= 1'b0;
            r_last_change <= 32'd0;
            r_edge_cnt    <= 8'sd0;
            r_last_report <= 32'd0;
        end else if (i_accept) begin
            r_stable      <= n_stable;
            r_prev        <= i_pin_level;
            r_last_change <= n_last_change;
            r_edge_cnt    <= n_edge_cnt;
            r_last_report <= n_last_report;
        end
    end

endmodule

`default_nettype wire

>>> design/bmhc_queue.sv
// Short command queue between the front end and the report engine.
`default_nettype none

module bmhc_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire bmhc_pkg::t_cmd    i_cmd,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_empty,
    output bmhc_pkg::t_cmd         o_cmd
);
    import bmhc_pkg::*;

    t_cmd                r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wptr;
    logic [Q_PTR_W-1:0]  r_rptr;
    logic [Q_CNT_W-1:0]  r_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_slot[r_rptr];

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue pushed while full");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

>>> design/bmhc_back.sv
// Report engine: emits tap reports and computes hold steps with a serial divider.
`default_nettype none

module bmhc_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_empty,
    input  wire bmhc_pkg::t_cmd    i_cmd,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_report_kind,
    output logic [31:0]            o_report_value,
    output logic                   o_last_of_run
);
    import bmhc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TAP  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic                  r_hold_vld;
    logic [5:0]            r_tap_val;
    logic [31:0]           r_quo;
    logic [15:0]           r_rem;
    logic [15:0]           r_div;
    logic [DIV_CNT_W-1:0]  r_cnt;

    logic                  r_ovld;
    logic                  r_kind;
    logic [31:0]           r_value;
    logic                  r_last;

    logic                  out_free;
    logic [16:0]           trial;
    logic                  fits;
    logic [16:0]           trial_sub;

    assign out_free = !r_ovld || !i_out_stall;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;

    // One restoring division step
    always_comb begin
        trial     = {r_rem, r_quo[31]};
        fits      = trial >= {1'b0, r_div};
        trial_sub = trial - {1'b0, r_div};
    end

    // Sequence the reports of one command
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_state = i_cmd.tap_vld ? S_TAP : S_DIV;
                end
            end
            S_TAP: begin
                if (out_free) begin
                    n_state = r_hold_vld ? S_DIV : S_IDLE;
                end
            end
            S_DIV: begin
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Load a command and run the divider
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_hold_vld <= i_cmd.hold_vld;
            r_tap_val  <= i_cmd.tap_val;
            r_quo      <= i_cmd.held_ms;
            r_rem      <= 16'd0;
            r_div      <= i_cmd.rep_ms;
            r_cnt      <= '0;
        end else if (r_state == S_DIV) begin
            r_quo <= {r_quo[30:0], fits};
            r_rem <= fits ? trial_sub[15:0] : trial[15:0];
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Hold the output beat until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (out_free) begin
            r_ovld <= (r_state == S_TAP) || (r_state == S_HOLD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && (r_state == S_TAP)) begin
            r_kind  <= KIND_TAP;
            r_value <= {26'd0, r_tap_val};
            r_last  <= !r_hold_vld;
        end else if (out_free && (r_state == S_HOLD)) begin
            r_kind  <= KIND_HOLD;
            r_value <= (&r_quo) ? r_quo : r_quo + 32'd1;
            r_last  <= 1'b1;
        end
    end

    assign o_out_valid    = r_ovld;
    assign o_report_kind  = r_kind;
    assign o_report_value = r_value;
    assign o_last_of_run  = r_last;

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_div != 16'd0))
        else $error("hold divider started with a zero divisor");
    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && (r_kind == KIND_HOLD)) |-> r_last)
        else $error("hold report not marked last");
    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && (r_kind == KIND_TAP)) |-> (r_value != 32'd0) && (r_value < 32'd64))
        else $error("tap report value out of range");

endmodule

`default_nettype wire

>>> design/button_multitap_hold_counter.sv
// Top level: configuration registers and the front end, queue and report engine.
//
// Debounces a sampled button pin, counts taps and reports long holds. Each input
// beat (pin level plus millisecond time) is taken by the front end whenever its
// two-entry command queue has room; a beat that causes no report is not queued.
// The report engine pops a command and registers its tap report from the tap
// state; a hold report follows a 32-step serial divider (held time divided by
// the repeat interval). Registers are written over the APB port at byte
// addresses 0 (debounce), 4 (gap), 8 (repeat), 12 (hold level) and should
// only be written while no reports are pending.
`default_nettype none

module button_multitap_hold_counter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_pin_level,
    input  wire logic [31:0] i_now_ms,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_report_kind,
    output logic [31:0]      o_report_value,
    output logic             o_last_of_run
);
    import bmhc_pkg::*;

    logic [15:0] r_debounce_ms;
    logic [15:0] r_gap_ms;
    logic [15:0] r_repeat_ms;
    logic        r_hold_level;

    logic        cfg_wr;
    logic        in_accept;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    t_cmd        push_cmd;
    t_cmd        head_cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= RST_DEBOUNCE_MS;
            r_gap_ms      <= RST_GAP_MS;
            r_repeat_ms   <= RST_REPEAT_MS;
            r_hold_level  <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_DEBOUNCE: r_debounce_ms <= pwdata[15:0];
                REG_GAP:      r_gap_ms      <= pwdata[15:0];
                REG_REPEAT:   r_repeat_ms   <= pwdata[15:0];
                REG_HOLD_LVL: r_hold_level  <= pwdata[0];
                default:      r_hold_level  <= r_hold_level;
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        unique case (paddr[3:2])
            REG_DEBOUNCE: prdata = {16'd0, r_debounce_ms};
            REG_GAP:      prdata = {16'd0, r_gap_ms};
            REG_REPEAT:   prdata = {16'd0, r_repeat_ms};
            REG_HOLD_LVL: prdata = {31'd0, r_hold_level};
            default:      prdata = 32'd0;
        endcase
    end

    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !o_in_stall;

    bmhc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_pin_level   (i_pin_level),
        .i_now_ms      (i_now_ms),
        .i_debounce_ms (r_debounce_ms),
        .i_gap_ms      (r_gap_ms),
        .i_repeat_ms   (r_repeat_ms),
        .i_hold_level  (r_hold_level),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    bmhc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    bmhc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_cmd          (head_cmd),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_report_kind  (o_report_kind),
        .o_report_value (o_report_value),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the button multi-tap and hold counter.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bmhc_pkg::*;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int SETTLE_CYCLES = 60;
    localparam int NUM_PHASES    = 7;
    localparam int PHASE_ITEMS   = 50;
    localparam int OVERFLOW_PASS = 3;
    localparam int DIRECTED_ROWS = 28;

    // One report as seen on the output channel
    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic        last;
    } t_report;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    // Directed stimulus row; typed_count < 0 means the predictor supplies the results
    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  reg_idx;
        logic [15:0] reg_val;
        logic        pin;
        logic [31:0] now;
        int          typed_count;
        t_report     first;
        t_report     second;
    } t_stim_row;

    localparam t_report NO_REP = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_pin_level = 1'b0;
    logic [31:0] i_now_ms = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_report_kind;
    logic [31:0] o_report_value;
    logic        o_last_of_run;

    // Register mirror
    logic [15:0] cfg_debounce = RST_DEBOUNCE_MS;
    logic [15:0] cfg_gap = RST_GAP_MS;
    logic [15:0] cfg_repeat = RST_REPEAT_MS;
    logic        cfg_hold = 1'b0;

    // Predicted button state
    logic               settled_level = 1'b0;
    logic               prev_pin = 1'b0;
    logic [31:0]        change_ms = '0;
    logic signed [7:0]  edge_tally = '0;
    logic [31:0]        hold_mark_ms = '0;

    t_report     expected_reports[$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    int          idle_odds = 0;
    int          stall_odds = 0;
    int          stall_left = 0;
    logic        lvl = 1'b0;
    logic [31:0] t_ms = '0;

    // Directed rows: reset behavior, a tap run, both reports at once, bounce,
    // then zero settings with a wrapped quiet time for the saturated hold step
    t_stim_row directed [DIRECTED_ROWS] = '{
        '{ROW_SAMPLE, REG_DEBOUNCE, 16'd0, 1'b0, 32'd0, 0, NO_REP, NO_REP},
        '{ROW_SAMPLE, REG_DEBOUNCE, 16'd0, 1'b0, 32'd501, 1,
          '{KIND_HOLD, 32'd1, 1'b1}, NO_REP},
        '{ROW_SAMPLE, REG_DEBOUNCE, 16'd0, 1'b0, 32'd1002, 1,
          '{KIND_HOLD, 32'd2, 1'b1}, NO_REP},
        '{ROW_SAMPLE, REG_DEBOUNCE, 16'd0, 1'b1, 32'd1010, -1, NO_REP, NO_REP},
        '{ROW_SAMPLE, REG_DEBOUNCE, 16'd0, 1'b1, 32'd1061, -1, NO_REP, NO_REP},
        '{ROW_SAMPLE, REG_DEBOUNCE, 16'd0, 1'b0, 32'd1070, -1, NO_REP, NO_REP},
        '{ROW_SAMPLE, REG_DEBOUNCE, 16'd0, 1'b0, 32'd1121, -1, NO_REP, NO_REP},
        '{ROW_SAMPLE, REG_DEBOUNCE, 16'd0, 1'b1, 32'd1130, -1, NO_REP, NO_REP},
        '{ROW_SAMPLE, REG_DEBOUNCE, 16'd0, 1'b1, 32'd1181, -1, NO_REP, NO_REP},
        '{ROW_SAMPLE, REG_DEBOUNCE, 16'd0, 1'b0, 32'd1190, -1, NO_REP, NO_REP},
        '{ROW_SAMPLE, REG_DEBOUNCE, 16'd0, 1'b0, 32'd1241, -1, NO_REP, NO_REP},
        '{ROW_SAMPLE, REG_DEBOUNCE, 16'd0, 1'b1, 32'd1250, -1, NO_REP, NO_REP},
        '{ROW_SAMPLE, REG_DEBOUNCE, 16'd0, 1'b1, 32'd1301, -1, NO_REP, NO_REP},
        '{ROW_SAMPLE, REG_DEBOUNCE, 16'd0, 1'b0, 32'd1310, -1, NO_REP, NO_REP},
        '{ROW_SAMPLE, REG_DEBOUNCE, 16'd0, 1'b0, 32'd1361, -1, NO_REP, NO_REP},
        '{ROW_SAMPLE, REG_DEBOUNCE, 16'd0, 1'b0, 32'd1900, 2,
          '{KIND_TAP, 32'd2, 1'b0}, '{KIND_HOLD, 32'd1, 1'b1}},
        '{ROW_SAMPLE, REG_DEBOUNCE, 16'd0, 1'b1, 32'd1910, -1, NO_REP, NO_REP},
        '{ROW_SAMPLE, REG_DEBOUNCE, 16'd0, 1'b0, 32'd1920, -1, NO_REP, NO_REP},
        '{ROW_SAMPLE, REG_DEBOUNCE, 16'd0, 1'b0, 32'd1950, -1, NO_REP, NO_REP},
        '{ROW_WRITE, REG_DEBOUNCE, 16'd0, 1'b0, 32'd0, 0, NO_REP, NO_REP},
        '{ROW_WRITE, REG_GAP, 16'd0, 1'b0, 32'd0, 0, NO_REP, NO_REP},
        '{ROW_WRITE, REG_REPEAT, 16'd0, 1'b0, 32'd0, 0, NO_REP, NO_REP},
        '{ROW_WRITE, REG_HOLD_LVL, 16'd1, 1'b0, 32'd0, 0, NO_REP, NO_REP},
        '{ROW_SAMPLE, REG_DEBOUNCE, 16'd0, 1'b1, 32'd5000, 0, NO_REP, NO_REP},
        '{ROW_SAMPLE, REG_DEBOUNCE, 16'd0, 1'b1, 32'd4999, 1,
          '{KIND_HOLD, 32'hFFFF_FFFF, 1'b1}, NO_REP},
        '{ROW_SAMPLE, REG_DEBOUNCE, 16'd0, 1'b1, 32'hFFFF_FFFF, -1, NO_REP, NO_REP},
        '{ROW_SAMPLE, REG_DEBOUNCE, 16'd0, 1'b0, 32'd2, -1, NO_REP, NO_REP},
        '{ROW_SAMPLE, REG_DEBOUNCE, 16'd0, 1'b0, 32'd4, -1, NO_REP, NO_REP}
    };

    button_multitap_hold_counter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pin_level    (i_pin_level),
        .i_now_ms       (i_now_ms),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_report_kind  (o_report_kind),
        .o_report_value (o_report_value),
        .o_last_of_run  (o_last_of_run)
    );

    always #4 i_clk = ~i_clk;

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Advance the predicted button state by one sample and return its reports
    task automatic classify_sample(input logic pin, input logic [31:0] now, output int n,
                                   output t_report first, output t_report second);
        logic [31:0] rep;
        logic [31:0] gap;
        logic [31:0] quiet;
        logic [31:0] held;
        logic [31:0] quot;
        logic [31:0] step;
        rep = (cfg_repeat == 16'd0) ? 32'd1 : {16'd0, cfg_repeat};
        gap = {16'd0, cfg_gap};
        n = 0;
        first = NO_REP;
        second = NO_REP;
        if (pin != prev_pin) begin
            change_ms = now;
        end
        quiet = now - change_ms;
        if (quiet > {16'd0, cfg_debounce}) begin
            // count a debounced edge, holding at the top
            if (pin != settled_level) begin
                if (edge_tally < EDGE_MAX) begin
                    edge_tally = edge_tally + 8'sd1;
                end
                settled_level = pin;
            end
            // close a tap run after the gap
            if (edge_tally > 8'sd1 && quiet > gap) begin
                first = '{KIND_TAP, 32'(edge_tally[6:1]), 1'b1};
                n = 1;
                edge_tally = 8'sd0;
            end
            // step a long hold once per repeat interval
            if ((now - hold_mark_ms) > rep && pin == cfg_hold && quiet > gap) begin
                held = quiet - gap;
                quot = held / rep;
                step = (quot == 32'hFFFF_FFFF) ? quot : quot + 32'd1;
                hold_mark_ms = now;
                if (n == 1) begin
                    first.last = 1'b0;
                    second = '{KIND_HOLD, step, 1'b1};
                end else begin
                    first = '{KIND_HOLD, step, 1'b1};
                end
                n++;
                edge_tally = -8'sd1;
            end
        end
        prev_pin = pin;
    endtask

    // Offer one sample beat, wait for it to be taken and queue what it should cause
    task automatic send_sample(input logic pin, input logic [31:0] now, input int typed_count,
                               input t_report typed_first, input t_report typed_second);
        t_report first;
        t_report second;
        int      n;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_pin_level <= pin;
        i_now_ms    <= now;
        do @(posedge i_clk); while (o_in_stall);
        classify_sample(pin, now, n, first, second);
        if (typed_count < 0) begin
            if (n > 0) expected_reports.push_back(first);
            if (n > 1) expected_reports.push_back(second);
        end else begin
            if (typed_count > 0) expected_reports.push_back(typed_first);
            if (typed_count > 1) expected_reports.push_back(typed_second);
        end
        lvl = pin;
        items_sent++;
    endtask

    // Advance the time cursor and send a sample checked by the predictor
    task automatic feed(input logic pin, input logic [31:0] dt);
        t_ms = t_ms + dt;
        send_sample(pin, t_ms, -1, NO_REP, NO_REP);
    endtask

    // Drain outstanding reports, let the engine go quiet, then write one register
    task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DEBOUNCE: cfg_debounce = val;
            REG_GAP:      cfg_gap = val;
            REG_REPEAT:   cfg_repeat = val;
            REG_HOLD_LVL: cfg_hold = val[0];
            default:      ;
        endcase
    endtask

    function automatic logic [15:0] pick_setting(input int hi_small);
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(1, hi_small));
        endcase
    endfunction

    function automatic int pick_odds();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 3;
            default: return 9;
        endcase
    endfunction

    // Mostly well-formed tap runs and holds, with bounce, noise and time jumps
    task automatic random_phase(input int count, input bit calm);
        int          first_item;
        int          sel;
        logic [31:0] deb32;
        logic [31:0] gap32;
        logic [31:0] rep32;
        deb32 = {16'd0, cfg_debounce};
        gap32 = {16'd0, cfg_gap};
        rep32 = (cfg_repeat == 16'd0) ? 32'd1 : {16'd0, cfg_repeat};
        idle_odds  = calm ? 0 : pick_odds();
        stall_odds = calm ? 0 : pick_odds();
        t_ms = $urandom;
        first_item = items_sent;
        while (items_sent - first_item < count) begin
            sel = $urandom_range(0, 9);
            if (sel <= 3) begin
                // tap run: each edge settles past the debounce time, some bounce first
                repeat (2 * $urandom_range(1, 5)) begin
                    feed(~lvl, $urandom_range(1, 3));
                    if ($urandom_range(0, 2) == 0) begin
                        feed(~lvl, 1);
                        feed(~lvl, 1);
                    end
                    feed(lvl, deb32 + 1 + $urandom_range(0, 30));
                end
                feed(lvl, gap32 + 1 + $urandom_range(0, 40));
            end else if (sel <= 6) begin
                // hold at the hold level, stepping through repeat intervals
                if (lvl != cfg_hold) begin
                    feed(cfg_hold, 1);
                    feed(cfg_hold, deb32 + 1);
                end
                feed(cfg_hold, gap32 + 1 + $urandom_range(0, rep32));
                repeat ($urandom_range(1, 5)) begin
                    feed(cfg_hold, ($urandom_range(0, 3) == 0) ? $urandom
                                                              : $urandom_range(0, 2 * rep32));
                end
                feed(~cfg_hold, 1);
                feed(lvl, deb32 + 1);
            end else if (sel <= 8) begin
                // noise: random levels at short random spacing
                repeat ($urandom_range(2, 6)) begin
                    feed(1'($urandom_range(0, 1)), $urandom_range(0, 2 * deb32 + 2));
                end
            end else begin
                // jump the clock anywhere, wrapping freely
                t_ms = $urandom;
                feed(lvl, 0);
            end
        end
    endtask

    // Output side: random stall bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            stall_left  <= $urandom_range(0, 12);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Compare each accepted report beat with the oldest expectation
    always @(posedge i_clk) begin : check_reports
        t_report want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_reports.size() == 0) begin
                flag_mismatch($sformatf("unexpected report kind %0d value %0d last %0d",
                                        o_report_kind, o_report_value, o_last_of_run));
            end else begin
                want = expected_reports.pop_front();
                if (o_report_kind !== want.kind)
                    flag_mismatch($sformatf("report_kind %0d, want %0d",
                                            o_report_kind, want.kind));
                if (o_report_value !== want.value)
                    flag_mismatch($sformatf("report_value %0d, want %0d",
                                            o_report_value, want.value));
                if (o_last_of_run !== want.last)
                    flag_mismatch($sformatf("last_of_run %0d, want %0d",
                                            o_last_of_run, want.last));
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** button_multitap_hold_counter: FAILED **");
        $finish;
    end

    initial begin
        int p;
        int i;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        idle_odds  = 4;
        stall_odds = 4;
        for (i = 0; i < DIRECTED_ROWS; i++) begin
            if (directed[i].kind == ROW_WRITE) begin
                write_register(directed[i].reg_idx, directed[i].reg_val);
            end else begin
                send_sample(directed[i].pin, directed[i].now, directed[i].typed_count,
                            directed[i].first, directed[i].second);
            end
        end

        // random phases, each under its own settings; the first at the maxima
        for (p = 0; p < NUM_PHASES; p++) begin
            if (p == OVERFLOW_PASS) begin
                // drive the edge count into saturation with a long run of quick taps
                write_register(REG_DEBOUNCE, 16'd0);
                write_register(REG_GAP, 16'hFFFF);
                write_register(REG_REPEAT, pick_setting(800));
                write_register(REG_HOLD_LVL, 16'($urandom_range(0, 1)));
                t_ms = $urandom;
                repeat (140) begin
                    feed(~lvl, 1);
                    feed(lvl, 1);
                end
                feed(lvl, 32'd65537);
            end
            write_register(REG_DEBOUNCE, (p == 0) ? 16'hFFFF : pick_setting(120));
            write_register(REG_GAP, (p == 0) ? 16'hFFFF : pick_setting(1500));
            write_register(REG_REPEAT, (p == 0) ? 16'hFFFF : pick_setting(800));
            write_register(REG_HOLD_LVL, (p == 0) ? 16'd1 : 16'($urandom_range(0, 1)));
            random_phase(PHASE_ITEMS, p == NUM_PHASES - 1);
        end

        // drain and let the engine go quiet
        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("** button_multitap_hold_counter: PASSED **");
        end else begin
            $display("** button_multitap_hold_counter: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/bmhc_pkg.sv
design/bmhc_front.sv
design/bmhc_queue.sv
design/bmhc_back.sv
design/button_multitap_hold_counter.sv
tb/testbench.sv
